// ===== hdl/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types, constants and the byte-wide CRC-16/MODBUS update for the
// CRC-checked frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

  // build-time limit on the frame length
  localparam int unsigned CFP_MAX_FRAME_BYTES = 512;

  // frame layout
  localparam logic [15:0] MIN_FRAME_BYTES = 16'd16;
  localparam int unsigned COUNT_W         = 10;
  localparam int unsigned POS_W           = 9;

  // byte counts (count after the current byte) that mark header fields
  localparam logic [COUNT_W-1:0] CNT_SYNC_LO  = 10'd1;
  localparam logic [COUNT_W-1:0] CNT_SYNC_HI  = 10'd2;
  localparam logic [COUNT_W-1:0] CNT_LENGTH   = 10'd4;
  localparam logic [COUNT_W-1:0] CNT_CPL      = 10'd6;
  localparam logic [COUNT_W-1:0] CNT_SOURCE   = 10'd8;
  localparam logic [COUNT_W-1:0] CNT_DEST     = 10'd10;
  localparam logic [COUNT_W-1:0] CNT_MAIN     = 10'd12;
  localparam logic [COUNT_W-1:0] CNT_SUB      = 10'd14;
  localparam logic [COUNT_W-1:0] CNT_BODY     = 10'd15;
  localparam logic [COUNT_W-1:0] CNT_MIN_END  = 10'd16;

  // crc-16/modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // configuration registers
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [7:0]  SYNC_BYTE_RST = 8'hAA;
  localparam logic [9:0]  MAX_LEN_RST   = 10'd512;

  typedef enum logic [0:0] {
    CFG_SYNC_BYTE = 1'b0,
    CFG_MAX_LEN   = 1'b1
  } cfg_idx_e;

  // per-byte event codes
  typedef enum logic [2:0] {
    EV_DISCARD = 3'd0,
    EV_HEADER  = 3'd1,
    EV_BODY    = 3'd2,
    EV_GOOD    = 3'd3,
    EV_CRC_ERR = 3'd4,
    EV_LEN_ERR = 3'd5,
    EV_CPL_ERR = 3'd6
  } event_e;

  // one result item
  typedef struct packed {
    event_e            event_res;
    logic [POS_W-1:0]  position;
    logic [7:0]        byte_echo;
    logic [15:0]       frame_length;
    logic [15:0]       source_address;
    logic [15:0]       dest_address;
    logic [15:0]       main_function;
    logic [15:0]       sub_function;
  } cfp_result_t;

  // reflected crc update over one byte, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cfp_if.sv =====
// ----------------------------------------------------------------------------
// cfp_if
// Valid/ready channels of the frame parser: received bytes in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
  modport monitor (input valid, input data_byte, input ready);
endinterface

interface cfp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [8:0]  position;
  logic [7:0]  byte_echo;
  logic [15:0] frame_length;
  logic [15:0] source_address;
  logic [15:0] dest_address;
  logic [15:0] main_function;
  logic [15:0] sub_function;

  modport source (
    output valid, output event_res, output position, output byte_echo,
    output frame_length, output source_address, output dest_address,
    output main_function, output sub_function, input ready
  );
  modport sink (
    input valid, input event_res, input position, input byte_echo,
    input frame_length, input source_address, input dest_address,
    input main_function, input sub_function, output ready
  );
  modport monitor (
    input valid, input event_res, input position, input byte_echo,
    input frame_length, input source_address, input dest_address,
    input main_function, input sub_function, input ready
  );
endinterface

`default_nettype wire

// ===== hdl/cfp_parser.sv =====
// ----------------------------------------------------------------------------
// cfp_parser
// Frame state: byte counter, captured header words and running CRC. Works
// out the event of each transferred byte and advances the state.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_parser
  import cfp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = CFP_MAX_FRAME_BYTES
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic [7:0]       sync_byte_i,
  input  wire logic [9:0]       max_len_i,
  output cfp_result_t           res_o
);

  logic [COUNT_W-1:0] count_q, count_d;
  logic [7:0]         prev_q;
  logic [15:0]        len_q, len_d;
  logic [15:0]        src_q, src_d;
  logic [15:0]        dst_q, dst_d;
  logic [15:0]        main_q, main_d;
  logic [15:0]        sub_q, sub_d;
  logic [15:0]        crc_q, crc_d;

  logic [COUNT_W-1:0] cnt;
  logic [15:0]        word;
  logic [15:0]        limit;
  logic [15:0]        param_max;
  logic               restart;
  event_e             ev;

  assign param_max = 16'(MAX_FRAME_BYTES);

  // effective length limit
  always_comb begin
    if (param_max < {6'd0, max_len_i}) begin
      limit = param_max;
    end else begin
      limit = {6'd0, max_len_i};
    end
  end

  // per-byte decode
  always_comb begin
    crc_d   = crc16_byte((count_q == '0) ? CRC_INIT : crc_q, data_byte_i);
    word    = {data_byte_i, prev_q};
    cnt     = count_q + COUNT_W'(1);
    ev      = EV_HEADER;
    restart = 1'b0;
    len_d   = len_q;
    src_d   = src_q;
    dst_d   = dst_q;
    main_d  = main_q;
    sub_d   = sub_q;

    if (cnt == CNT_SYNC_LO || cnt == CNT_SYNC_HI) begin
      if (data_byte_i != sync_byte_i) begin
        ev      = EV_DISCARD;
        restart = 1'b1;
      end
    end else if (cnt == CNT_LENGTH) begin
      len_d = word;
      if (word < MIN_FRAME_BYTES || word > limit) begin
        ev      = EV_LEN_ERR;
        restart = 1'b1;
      end
    end else if (cnt == CNT_CPL) begin
      if (~word != len_q) begin
        ev      = EV_CPL_ERR;
        restart = 1'b1;
      end
    end else if (cnt == CNT_SOURCE) begin
      src_d = word;
    end else if (cnt == CNT_DEST) begin
      dst_d = word;
    end else if (cnt == CNT_MAIN) begin
      main_d = word;
    end else if (cnt == CNT_SUB) begin
      sub_d = word;
    end else if (cnt >= CNT_MIN_END && {6'd0, cnt} >= len_q) begin
      // closing byte: residue of a good frame is zero
      ev      = (crc_d == 16'h0000) ? EV_GOOD : EV_CRC_ERR;
      restart = 1'b1;
    end else if (cnt >= CNT_BODY) begin
      ev = EV_BODY;
    end

    count_d = restart ? '0 : cnt;
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      prev_q  <= '0;
      len_q   <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      main_q  <= '0;
      sub_q   <= '0;
      crc_q   <= CRC_INIT;
    end else if (step_i) begin
      count_q <= count_d;
      prev_q  <= data_byte_i;
      len_q   <= len_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      main_q  <= main_d;
      sub_q   <= sub_d;
      crc_q   <= crc_d;
    end
  end

  // result of the current byte
  always_comb begin
    res_o.event_res      = ev;
    res_o.position       = count_q[POS_W-1:0];
    res_o.byte_echo      = data_byte_i;
    res_o.frame_length   = len_d;
    res_o.source_address = src_d;
    res_o.dest_address   = dst_d;
    res_o.main_function  = main_d;
    res_o.sub_function   = sub_d;
  end

endmodule

`default_nettype wire

// ===== hdl/crc_checked_frame_parser.sv =====
// ----------------------------------------------------------------------------
// crc_checked_frame_parser
// Length-framed packet parser with on-the-fly CRC-16/MODBUS check.
// ----------------------------------------------------------------------------
// Takes one received byte per transfer and returns one result per byte. A
// byte is taken in every clock cycle as long as the result port is not
// stalled; its result appears in the output register on the next cycle, so
// throughput is one byte per cycle. The input is ready whenever the output
// register is empty or is being drained in the same cycle. The event code
// tells header bytes, body bytes, a good frame, a CRC error, a length error,
// a complement error and bytes discarded while hunting for the two sync
// bytes. Configuration is to be written through the write port while no
// transfer is in flight (the block does not enforce this): register 0 sets
// the sync byte, register 1 the largest accepted frame length, limited
// further by MAX_FRAME_BYTES.
`default_nettype none

module crc_checked_frame_parser
  import cfp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = CFP_MAX_FRAME_BYTES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [0:0]            cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  cfp_byte_if.sink                   in_ch,
  cfp_result_if.source               out_ch
);

  logic [7:0]  sync_byte_q;
  logic [9:0]  max_len_q;
  logic        out_valid_q;
  cfp_result_t res_q;
  cfp_result_t res_d;
  logic        in_xfer;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_byte_q <= SYNC_BYTE_RST;
      max_len_q   <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SYNC_BYTE: sync_byte_q <= cfg_data_i[7:0];
        CFG_MAX_LEN:   max_len_q   <= cfg_data_i[9:0];
        default:       ;
      endcase
    end
  end

  // input transfer whenever the output register can take the result
  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  cfp_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_xfer),
    .data_byte_i (in_ch.data_byte),
    .sync_byte_i (sync_byte_q),
    .max_len_i   (max_len_q),
    .res_o       (res_d)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.event_res      = res_q.event_res;
  assign out_ch.position       = res_q.position;
  assign out_ch.byte_echo      = res_q.byte_echo;
  assign out_ch.frame_length   = res_q.frame_length;
  assign out_ch.source_address = res_q.source_address;
  assign out_ch.dest_address   = res_q.dest_address;
  assign out_ch.main_function  = res_q.main_function;
  assign out_ch.sub_function   = res_q.sub_function;

endmodule

`default_nettype wire

// ===== hdl/cfp_checker.sv =====
// ----------------------------------------------------------------------------
// cfp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_checker
  import cfp_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic [7:0] in_data_byte_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] out_event_res_i,
  input wire logic [8:0] out_position_i,
  input wire logic [7:0] out_byte_echo_i
);

  // a stalled result holds its byte
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_echo_i))
    else $error("result changed while stalled");

  // no input transfer while a result waits
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken over a stalled result");

  // an input transfer gives its byte at the output next cycle
  a_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i
      && out_byte_echo_i == $past(in_data_byte_i))
    else $error("result does not echo the transferred byte");

  // header bytes sit in the first fourteen offsets, body bytes after them
  a_layout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (out_event_res_i != EV_HEADER || out_position_i < 9'd14) &&
      (out_event_res_i != EV_BODY || out_position_i >= 9'd14) &&
      (out_event_res_i != EV_GOOD || out_position_i >= 9'd15))
    else $error("event does not match frame offset");

endmodule

bind crc_checked_frame_parser cfp_checker u_cfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_ch.valid),
  .in_ready_i      (in_ch.ready),
  .in_data_byte_i  (in_ch.data_byte),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .out_event_res_i (out_ch.event_res),
  .out_position_i  (out_ch.position),
  .out_byte_echo_i (out_ch.byte_echo)
);

`default_nettype wire
